>>> hdl/rfc_pkg.sv
// Shared types and constants for the reciprocal frequency counter.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

  localparam int unsigned CNT_W      = 32;
  localparam int unsigned FREQ_W     = 40;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned DIV_STEPS  = FREQ_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0]  CLOCK_HZ_RST   = 32'd84000000;
  localparam logic [CNT_W-1:0]  TIMEOUT_MS_RST = 32'd1000;
  localparam logic [STEP_W-1:0] STEP_LOAD      = STEP_W'(DIV_STEPS);

  typedef enum logic [0:0] {
    REG_CLOCK_HZ   = 1'b0,
    REG_TIMEOUT_MS = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_CAPTURE = 1'b0,
    KIND_CHECK   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic div_start;  // load the divider
    logic div_step;   // one restoring-divide step
    logic commit;     // update held state and load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;   // latched item is a second capture with nonzero period
    logic div_done;   // all quotient bits formed
    logic out_free;   // output register can take a new result
  } status_t;

endpackage

`default_nettype wire

>>> hdl/rfc_ctrl.sv
// Controller state machine for the reciprocal frequency counter.
// Depends on rfc_pkg (state, command and status types).
`timescale 1ns / 1ps
`default_nettype none

module rfc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  rfc_pkg::status_t     status,
  output rfc_pkg::cmd_t        cmd
);
  import rfc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/rfc_dp.sv
// Datapath for the reciprocal frequency counter: config registers, item
// latch, pair/held state, restoring divider and output register. Uses rfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfc_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  rfc_pkg::reg_idx_t                cfg_index,
  input  wire logic [rfc_pkg::CNT_W-1:0]   cfg_data,
  input  rfc_pkg::kind_t                   kind,
  input  wire logic [rfc_pkg::CNT_W-1:0]   capture_value,
  input  wire logic [rfc_pkg::CNT_W-1:0]   now_ms,
  input  rfc_pkg::cmd_t                    cmd,
  output rfc_pkg::status_t                 status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rfc_pkg::FREQ_W-1:0]       freq_fixed,
  output logic                             freq_ok,
  output logic                             new_result
);
  import rfc_pkg::*;

  logic [CNT_W-1:0]  clock_hz;
  logic [CNT_W-1:0]  timeout_ms;

  kind_t             kind_q;
  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  now_q;

  logic [CNT_W-1:0]  first_edge;
  logic              awaiting_second;
  logic [FREQ_W-1:0] held_freq;
  logic              held_valid;
  logic [CNT_W-1:0]  last_edge_ms;

  logic [CNT_W-1:0]  rem;
  logic [FREQ_W-1:0] quo;
  logic [STEP_W-1:0] steps;

  logic [CNT_W-1:0]  period;
  logic [CNT_W-1:0]  elapsed;
  logic              timed_out;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_diff;
  logic              qbit;

  logic              first_edge_we;
  logic              awaiting_next;
  logic [FREQ_W-1:0] held_freq_next;
  logic              held_valid_next;
  logic              fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz   <= CLOCK_HZ_RST;
      timeout_ms <= TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_HZ:   clock_hz   <= cfg_data;
        REG_TIMEOUT_MS: timeout_ms <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= kind;
      cap_q  <= capture_value;
      now_q  <= now_ms;
    end
  end

  assign period    = cap_q - first_edge;
  assign elapsed   = now_q - last_edge_ms;
  assign timed_out = held_valid && (elapsed > timeout_ms);

  // Restoring divide of clock_hz * 256 by period, one quotient bit per step
  assign trial      = {rem, quo[FREQ_W-1]};
  assign trial_diff = trial - {1'b0, period};
  assign qbit       = !trial_diff[CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.div_start) begin
      steps <= STEP_LOAD;
    end else if (cmd.div_step) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= {clock_hz, {FRAC_W{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= qbit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[FREQ_W-2:0], qbit};
    end
  end

  always_comb begin
    first_edge_we   = 1'b0;
    awaiting_next   = awaiting_second;
    held_freq_next  = held_freq;
    held_valid_next = held_valid;
    fresh           = 1'b0;
    if (kind_q == KIND_CAPTURE) begin
      if (!awaiting_second) begin
        first_edge_we = 1'b1;
        awaiting_next = 1'b1;
      end else begin
        awaiting_next = 1'b0;
        if (period != '0) begin
          held_freq_next  = quo;
          held_valid_next = 1'b1;
          fresh           = 1'b1;
        end
      end
    end else if (timed_out) begin
      held_freq_next  = '0;
      held_valid_next = 1'b0;
      awaiting_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_edge      <= '0;
      awaiting_second <= 1'b0;
      held_freq       <= '0;
      held_valid      <= 1'b0;
      last_edge_ms    <= '0;
    end else if (cmd.commit) begin
      if (first_edge_we) begin
        first_edge <= cap_q;
      end
      if (kind_q == KIND_CAPTURE) begin
        last_edge_ms <= now_q;
      end
      awaiting_second <= awaiting_next;
      held_freq       <= held_freq_next;
      held_valid      <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      freq_fixed <= held_freq_next;
      freq_ok    <= held_valid_next;
      new_result <= fresh;
    end
  end

  assign status.need_div = (kind_q == KIND_CAPTURE) && awaiting_second && (period != '0);
  assign status.div_done = (steps == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> hdl/reciprocal_frequency_counter_unit.sv
// Top level of the reciprocal frequency counter: ties controller and datapath.
// Depends on rfc_pkg, rfc_ctrl and rfc_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one item: kind, capture_value,
//   now_ms. kind selects an edge capture or a timeout check.
//   Output channel (out_valid/out_ready) moves exactly one result item per
//   input item: freq_fixed (32.8 unsigned hertz), freq_ok, new_result.
//   Config port: cfg_we writes cfg_data into register cfg_index
//   (0 = clock_hz, 1 = timeout_ms) in the same cycle; write only while idle.
// Timing:
//   One item at a time. An item that closes a pair with a nonzero period runs
//   the 40-step restoring divider (one quotient bit per cycle) before its
//   result is committed; every other item commits without dividing.
//   in_ready is high only while the controller is idle.
// Stall:
//   The result sits in an output register, so the next item is accepted
//   while it waits; that item's commit holds until the register is taken.
// Reset:
//   rst (synchronous, active high) clears the pair and held state, reloads
//   clock_hz = 84000000 and timeout_ms = 1000, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module reciprocal_frequency_counter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  rfc_pkg::reg_idx_t                cfg_index,
  input  wire logic [rfc_pkg::CNT_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  rfc_pkg::kind_t                   kind,
  input  wire logic [rfc_pkg::CNT_W-1:0]   capture_value,
  input  wire logic [rfc_pkg::CNT_W-1:0]   now_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rfc_pkg::FREQ_W-1:0]       freq_fixed,
  output logic                             freq_ok,
  output logic                             new_result
);
  import rfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing: accept, evaluate, optionally divide, commit
  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, divider and output stage
  rfc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .capture_value (capture_value),
    .now_ms        (now_ms),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .freq_fixed    (freq_fixed),
    .freq_ok       (freq_ok),
    .new_result    (new_result)
  );

endmodule

`default_nettype wire

>>> hdl/rfc_checker.sv
// Port-level checks for reciprocal_frequency_counter_unit, bound to the top.
// Depends on rfc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module rfc_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [rfc_pkg::FREQ_W-1:0]  freq_fixed,
  input  wire logic                        freq_ok,
  input  wire logic                        new_result
);

  // A fresh computation always leaves a valid measurement
  a_fresh_is_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!new_result || freq_ok))
    else $error("new_result without freq_ok");

  // Nothing held reads as zero frequency
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !freq_ok) |-> (freq_fixed == '0))
    else $error("freq_fixed nonzero while not valid");

  // One item at a time: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(freq_fixed) && $stable(freq_ok)
                                   && $stable(new_result)))
    else $error("stalled result changed");

endmodule

bind reciprocal_frequency_counter_unit rfc_checker u_rfc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .freq_fixed (freq_fixed),
  .freq_ok    (freq_ok),
  .new_result (new_result)
);

`default_nettype wire
